>>> rtl/sgbs_pkg.sv
// Shared types, constants and arithmetic helpers for the grid budget sum block.
// No dependencies.
`default_nettype none
package sgbs_pkg;
    localparam int unsigned MaxRowWidth = 1024;
    localparam int unsigned FracBits    = 16;
    localparam int unsigned PhBits      = 16;
    localparam int unsigned ColW        = $clog2(MaxRowWidth);
    localparam int unsigned AddrW       = ColW + 1;
    localparam logic [ColW-1:0] MaxNx   = ColW'(MaxRowWidth - 2);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_NX   = 3'd0,
        REG_NY   = 3'd1,
        REG_D1   = 3'd2,
        REG_D2   = 3'd3,
        REG_IDX  = 3'd4,
        REG_IDY  = 3'd5,
        REG_GRAV = 3'd6,
        REG_AREA = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [9:0]  nx;
        logic [12:0] ny;
        logic [31:0] d1;
        logic [31:0] d2;
        logic [31:0] idx;
        logic [31:0] idy;
        logic [31:0] grav;
        logic [31:0] area;
    } t_cfg;

    // One stored cell: pressure, total phase, wall phase sum, velocities.
    typedef struct packed {
        logic [31:0] p;
        logic [15:0] t;
        logic [16:0] w;
        logic [31:0] vx;
        logic [31:0] vy;
    } t_cell;

    // Sequencer steps of one cell request.
    typedef enum logic [4:0] {
        S_IDLE, S_RD_L, S_RD_C, S_RD_R, S_RD_U, S_WAIT, S_FACE, S_M1, S_M2,
        S_M3, S_M4, S_B1, S_B2, S_B3, S_B4, S_SUM, S_AREA, S_ACC, S_WR, S_OUT
    } t_seq;

    // Clamp a face average into [1, 65535].
    function automatic logic [15:0] clamp_ph(input logic [16:0] x);
        logic [15:0] r;
        begin
            if (x == 17'd0) r = 16'd1;
            else if (x[16]) r = 16'hFFFF;
            else r = x[15:0];
            return r;
        end
    endfunction

    // Saturating signed 64-bit add, with overflow flag.
    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] s;
        logic [64:0] r;
        begin
            s = {a[63], a} + {b[63], b};
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) r = {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
            else if (s < -65'sh0_8000_0000_0000_0000)
                r = {1'b1, 64'h8000_0000_0000_0000};
            else r = {1'b0, s[63:0]};
            return r;
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/sgbs_mul.sv
// Sequential signed multiply with rounding shift and 64-bit saturation.
// Uses sgbs_pkg; four 32x32 partial products and a rounding step, then done with the result.
`default_nettype none
module sgbs_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    input  wire logic [5:0]         i_sh,
    output logic                    o_done,
    output logic signed [63:0]      o_res
);
    import sgbs_pkg::*;

    logic         r_busy, n_busy;
    logic [4:0]   r_step, n_step;
    logic [63:0]  r_ma, r_mb;
    logic         r_neg;
    logic [5:0]   r_sh;
    logic [127:0] r_acc, n_acc;
    logic         r_done;
    logic [63:0]  r_res;
    logic [63:0]  w_ma, w_mb;
    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_pps, w_rnd;
    logic [127:0] w_shd;
    logic [63:0]  w_out;

    assign w_ma = i_a[63] ? 64'(-i_a) : i_a;
    assign w_mb = i_b[63] ? 64'(-i_b) : i_b;

    // Partial products: step bit0 picks a half, bit1 picks b half.
    always_comb begin
        w_pa  = r_step[0] ? r_ma[63:32] : r_ma[31:0];
        w_pb  = r_step[1] ? r_mb[63:32] : r_mb[31:0];
        w_pp  = 64'(w_pa) * 64'(w_pb);
        w_pps = 128'(w_pp) << (7'(r_step[0]) * 7'd32 + 7'(r_step[1]) * 7'd32);
        n_acc = r_acc;
        n_busy = r_busy;
        n_step = r_step;
        if (r_busy) begin
            if (r_step[2]) begin
                n_busy = 1'b0;
            end else begin
                n_acc  = r_acc + w_pps;
                n_step = r_step + 5'd1;
            end
        end
    end

    // Round half away from zero on the magnitude, then saturate.
    always_comb begin
        w_rnd = (r_sh == 6'd0) ? r_acc : r_acc + (128'd1 << (r_sh - 6'd1));
        w_shd = w_rnd >> r_sh;
        if (!r_neg) begin
            w_out = (w_shd[127:63] != 65'd0) ? 64'h7FFF_FFFF_FFFF_FFFF : w_shd[63:0];
        end else begin
            w_out = (w_shd[127:63] != 65'd0) ? 64'h8000_0000_0000_0000
                                              : 64'(-w_shd[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_step[2];
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else begin
                r_busy <= n_busy;
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= w_ma;
            r_mb  <= w_mb;
            r_neg <= i_a[63] ^ i_b[63];
            r_sh  <= i_sh;
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
        if (r_busy && r_step[2]) r_res <= w_out;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("product done without a running multiply");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_step <= 5'd4)
        else $error("multiply step counter overran");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) && !i_start |-> o_done)
        else $error("multiply finished without done pulse");
endmodule
`default_nettype wire

>>> rtl/sgbs_rows.sv
// Two-row cell store, one synchronous memory with registered read data.
// Uses sgbs_pkg for the cell record.
`default_nettype none
module sgbs_rows (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [sgbs_pkg::AddrW-1:0]  i_waddr,
    input  wire sgbs_pkg::t_cell             i_wdata,
    input  wire logic [sgbs_pkg::AddrW-1:0]  i_raddr,
    output sgbs_pkg::t_cell                  o_rdata
);
    import sgbs_pkg::*;

    t_cell r_mem [0:2*MaxRowWidth-1];
    t_cell r_rdata;

    // One write port, one read port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> rtl/staggered_grid_budget_sum.sv
// Top level of the staggered-grid budget sum; uses sgbs_pkg, sgbs_rows, sgbs_mul.
// Sequencer for row-store reads, face terms and saturating accumulation.
//
// Usage: cells enter on the s_axis request channel in raster order over
// (grid_nx+2) x (grid_ny+2) cells including the halo. tdata packs pressure,
// phase_total, phase_r, phase_m, vel_x, vel_y from bit 0 up. One result
// (budget_sum, saturated) leaves on m_axis after the last cell of a frame.
// Configuration is a plain write port, index per register list; the user must
// write it only while the block is idle, which the block itself does not enforce.
// A new cell is taken only in S_IDLE, so each request is finished before the
// next; a halo cell passes through S_RD_L and S_WR. An interior cell reads four
// stored neighbours (one read port, registered read data) and then runs 25
// products on one shared sequential multiplier built on 32x32 partial products.
// The total is registered in the S_WR step of the last cell of a frame.
// Reset clears counters, accumulator and flag; the row stores need no clear.
// When the receiver stalls, the result stays in the output register and no
// new cell is taken until it is accepted and the sequencer is back in S_IDLE.
`default_nettype none
module staggered_grid_budget_sum (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pressure[31:0], phase_total[47:32], phase_r[63:48], phase_m[79:64],
    // vel_x[111:80], vel_y[143:112]
    input  wire logic [143:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // budget_sum[63:0], saturated[64], zero fill to bit 71
    output logic [71:0]       m_axis_tdata
);
    import sgbs_pkg::*;

    t_cfg  r_cfg;
    t_seq  r_st, n_st;
    logic [9:0]  r_col;
    logic [12:0] r_row;
    logic signed [63:0] r_acc;
    logic        r_clip;
    logic [143:0] r_in;
    t_cell r_nb [0:3];
    logic [2:0]  r_rcnt;
    logic [1:0]  r_face;
    logic signed [63:0] r_g, r_b, r_tmp, r_ro, r_w, r_u;
    logic [15:0] r_ph;
    logic [71:0] r_out;
    logic        r_ovalid;

    logic [9:0]  w_nx;
    logic [AddrW-1:0] w_cur, w_prv, w_raddr;
    logic        w_interior;
    t_cell       w_in_cell, w_rdata;
    logic        w_mstart, w_mdone;
    logic signed [63:0] w_ma, w_mb, w_mres;
    logic [5:0]  w_msh;
    t_cell       w_fa, w_fb;
    logic [31:0] w_fvel;
    logic [16:0] w_wsum;
    logic [15:0] w_ph, w_pw;
    logic [64:0] w_add;
    logic [64:0] w_gadd, w_tadd;

    assign w_nx  = (r_cfg.nx > MaxNx) ? MaxNx : r_cfg.nx;
    assign w_cur = {r_row[0], ColW'(0)};
    assign w_prv = {~r_row[0], ColW'(0)};
    assign w_interior = (r_row >= 13'd2) && (14'(r_row) <= 14'(r_cfg.ny) + 14'd1)
                     && (r_col >= 10'd1) && (r_col <= w_nx);

    assign w_in_cell.p  = r_in[31:0];
    assign w_in_cell.t  = r_in[47:32];
    assign w_in_cell.w  = 17'(r_in[63:48]) + 17'(r_in[79:64]);
    assign w_in_cell.vx = r_in[111:80];
    assign w_in_cell.vy = r_in[143:112];

    // Neighbour read address by read step: left, centre, right, upper.
    always_comb begin
        unique case (r_rcnt)
            3'd0:    w_raddr = w_prv | AddrW'(r_col - 10'd1);
            3'd1:    w_raddr = w_prv | AddrW'(r_col);
            3'd2:    w_raddr = w_prv | AddrW'(r_col + 10'd1);
            default: w_raddr = w_cur | AddrW'(r_col);
        endcase
    end

    sgbs_rows u_rows (
        .i_clk   (i_clk),
        .i_we    (r_st == S_WR),
        .i_waddr (w_cur | AddrW'(r_col)),
        .i_wdata (w_in_cell),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Face operands: left, right, upper, lower faces.
    always_comb begin
        unique case (r_face)
            2'd0: begin w_fa = r_nb[0]; w_fb = r_nb[1]; w_fvel = r_nb[0].vx; end
            2'd1: begin w_fa = r_nb[1]; w_fb = r_nb[2]; w_fvel = r_nb[1].vx; end
            2'd2: begin w_fa = r_nb[3]; w_fb = r_nb[1]; w_fvel = r_nb[3].vy; end
            default: begin w_fa = r_nb[1]; w_fb = w_in_cell; w_fvel = r_nb[1].vy; end
        endcase
        w_ph   = clamp_ph((17'(w_fa.t) + 17'(w_fb.t)) >> 1);
        w_wsum = 17'((18'(w_fa.w) + 18'(w_fb.w)) >> 1);
        w_pw   = clamp_ph(w_wsum);
    end

    // Multiplier operand select per step.
    always_comb begin
        w_ma = r_g; w_mb = r_u; w_msh = 6'(FracBits);
        unique case (r_st)
            S_M1: begin w_ma = r_g; w_mb = 64'(r_cfg.d1); end
            S_M2: begin
                w_ma = r_g;
                w_mb = r_face[1] ? 64'(r_cfg.idy) : 64'(r_cfg.idx);
            end
            S_M3: begin w_ma = r_g; w_mb = r_u; end
            S_M4: begin w_ma = r_g; w_mb = r_w; w_msh = 6'(2*PhBits+1); end
            S_B1: begin
                w_ma = 64'(r_cfg.d2) - 64'(r_cfg.d1);
                w_mb = 64'(r_ph); w_msh = 6'(PhBits);
            end
            S_B2: begin w_ma = r_ro; w_mb = 64'(signed'(r_cfg.grav)); end
            S_B3: begin w_ma = r_b; w_mb = r_u; end
            S_B4: begin w_ma = r_b; w_mb = r_w; w_msh = 6'(2*PhBits+1); end
            S_AREA: begin w_ma = r_tmp; w_mb = 64'(r_cfg.area); w_msh = 6'd0; end
            default: ;
        endcase
    end

    logic r_mpend;
    assign w_mstart = !r_mpend && (r_st == S_M1 || r_st == S_M2 || r_st == S_M3
        || r_st == S_M4 || r_st == S_B1 || r_st == S_B2 || r_st == S_B3
        || r_st == S_B4 || r_st == S_AREA);

    sgbs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_sh    (w_msh),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    assign w_add  = sat_add(r_acc, w_mres);
    assign w_gadd = sat_add(r_g, w_mres);
    assign w_tadd = sat_add(r_tmp, r_g);

    // Next-step logic of the sequencer.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (s_axis_tvalid) n_st = S_RD_L;
            S_RD_L: n_st = w_interior ? S_RD_C : S_WR;
            S_RD_C: n_st = S_RD_R;
            S_RD_R: n_st = S_RD_U;
            S_RD_U: n_st = S_WAIT;
            S_WAIT: n_st = S_FACE;
            S_FACE: n_st = S_M1;
            S_M1: if (w_mdone) n_st = S_M2;
            S_M2: if (w_mdone) n_st = S_M3;
            S_M3: if (w_mdone) n_st = S_M4;
            S_M4: if (w_mdone) n_st = r_face[1] ? S_B1 : S_SUM;
            S_B1: if (w_mdone) n_st = S_B2;
            S_B2: if (w_mdone) n_st = S_B3;
            S_B3: if (w_mdone) n_st = S_B4;
            S_B4: if (w_mdone) n_st = S_SUM;
            S_SUM: n_st = (r_face == 2'd3) ? S_AREA : S_FACE;
            S_AREA: if (w_mdone) n_st = S_ACC;
            S_ACC: n_st = S_WR;
            S_WR: n_st = ((r_col >= w_nx + 10'd1) && (14'(r_row) >= 14'(r_cfg.ny) + 14'd1))
                       ? S_OUT : S_IDLE;
            S_OUT: if (!r_ovalid) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_acc    <= '0;
            r_clip   <= 1'b0;
            r_ovalid <= 1'b0;
            r_mpend  <= 1'b0;
            r_cfg.nx <= 10'd320;   r_cfg.ny <= 13'd320;
            r_cfg.d1 <= 32'd65536; r_cfg.d2 <= 32'd65536;
            r_cfg.idx <= 32'd65536; r_cfg.idy <= 32'd65536;
            r_cfg.grav <= 32'd0;   r_cfg.area <= 32'd65536;
        end else begin
            r_st <= n_st;
            if (w_mstart) r_mpend <= 1'b1;
            else if (w_mdone) r_mpend <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_NX:   r_cfg.nx   <= i_cfg_data[9:0];
                    REG_NY:   r_cfg.ny   <= i_cfg_data[12:0];
                    REG_D1:   r_cfg.d1   <= i_cfg_data;
                    REG_D2:   r_cfg.d2   <= i_cfg_data;
                    REG_IDX:  r_cfg.idx  <= i_cfg_data;
                    REG_IDY:  r_cfg.idy  <= i_cfg_data;
                    REG_GRAV: r_cfg.grav <= i_cfg_data;
                    REG_AREA: r_cfg.area <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_st == S_ACC) begin
                r_acc  <= w_add[63:0];
                r_clip <= r_clip | w_add[64];
            end
            // Advance raster counters and emit the frame total.
            if (r_st == S_WR) begin
                if (r_col >= w_nx + 10'd1) begin
                    r_col <= '0;
                    if (14'(r_row) >= 14'(r_cfg.ny) + 14'd1) begin
                        r_row    <= '0;
                        r_ovalid <= 1'b1;
                        r_acc    <= '0;
                        r_clip   <= 1'b0;
                    end else begin
                        r_row <= r_row + 13'd1;
                    end
                end else begin
                    r_col <= r_col + 10'd1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in <= s_axis_tdata;
        if (r_st == S_IDLE) r_rcnt <= 3'd0;
        else if (r_rcnt != 3'd7) r_rcnt <= r_rcnt + 3'd1;
        if (r_st == S_RD_C) r_nb[0] <= w_rdata;
        if (r_st == S_RD_R) r_nb[1] <= w_rdata;
        if (r_st == S_RD_U) r_nb[2] <= w_rdata;
        if (r_st == S_WAIT) begin
            r_nb[3] <= w_rdata;
            r_face  <= 2'd0;
            r_tmp   <= '0;
        end
        if (r_st == S_FACE) begin
            r_g  <= 64'(signed'(w_fb.p)) - 64'(signed'(w_fa.p));
            r_u  <= 64'(signed'(w_fvel));
            r_ph <= w_ph;
            r_w  <= 64'(32'(w_ph) * (32'h1_0000 - 32'(w_pw)));
        end
        if (w_mdone) begin
            unique case (r_st)
                S_M1, S_M2, S_M3, S_M4: r_g <= w_mres;
                S_B1: r_ro <= 64'(r_cfg.d1) + w_mres;
                S_B2, S_B3: r_b <= w_mres;
                S_B4: r_g <= w_gadd[63:0];
                default: ;
            endcase
        end
        if (r_st == S_SUM) begin
            r_tmp  <= w_tadd[63:0];
            r_face <= r_face + 2'd1;
        end
        if (r_st == S_WR) r_out <= {7'd0, r_clip, r_acc};
        if (r_st == S_ACC) r_out <= {7'd0, r_clip | w_add[64], w_add[63:0]};
    end

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");
    a_out_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> r_row == 13'd0 && r_col == 10'd0)
        else $error("result raised away from frame end");
    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> r_acc == 64'd0 && !r_clip)
        else $error("accumulator not cleared after result");
endmodule
`default_nettype wire

>>> dv/tb_staggered_grid_budget_sum.sv
// Testbench for staggered_grid_budget_sum: streams raster frames of grid cells and checks
// each frame total against a built-in fixed-point predictor. Depends on rtl/sgbs_pkg.sv.
`timescale 1ns / 1ps

import sgbs_pkg::*;

// Predicts frame totals from accepted cells and checks the totals that come out.
class budget_scoreboard;
    localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SMIN = 64'sh8000_0000_0000_0000;

    bit [9:0]  nx_reg;
    bit [12:0] ny_reg;
    bit [31:0] d1, d2, idx, idy, area;
    bit [31:0] grav;

    bit [31:0] p_rows[2048];
    bit [15:0] t_rows[2048];
    bit [16:0] w_rows[2048];
    bit [31:0] vx_rows[2048];
    bit [31:0] vy_rows[2048];
    int unsigned col_cnt, row_cnt;
    longint acc;
    bit clip;

    longint exp_sum[$];
    bit     exp_sat[$];
    int     errors;

    function new();
        nx_reg = 320; ny_reg = 320;
        d1 = 65536; d2 = 65536; idx = 65536; idy = 65536; grav = 0; area = 65536;
        col_cnt = 0; row_cnt = 0; acc = 0; clip = 0; errors = 0;
    endfunction

    function int pending();
        return exp_sum.size();
    endfunction

    // Exact product, shifted with rounding half away from zero, saturated to 64 bits.
    function longint mul_shift(longint a, longint b, int sh);
        bit neg;
        bit [63:0] ma, mb;
        bit [127:0] prod;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
        mb = (b < 0) ? 64'd0 - 64'(b) : 64'(b);
        prod = {64'd0, ma} * {64'd0, mb};
        if (sh > 0) prod = (prod + (128'd1 << (sh - 1))) >> sh;
        if (!neg) return (prod > 128'h7FFF_FFFF_FFFF_FFFF) ? SMAX : longint'(prod[63:0]);
        if (prod >= 128'h8000_0000_0000_0000) return SMIN;
        return -longint'(prod[63:0]);
    endfunction

    function longint sat_add(longint a, longint b, ref bit flag);
        if (b > 0 && a > SMAX - b) begin
            flag = 1;
            return SMAX;
        end
        if (b < 0 && a < SMIN - b) begin
            flag = 1;
            return SMIN;
        end
        return a + b;
    endfunction

    function bit [16:0] clamp_frac(bit [17:0] x);
        if (x == 0) return 1;
        if (x > 65535) return 65535;
        return x[16:0];
    endfunction

    // One face: pressure gradient term, plus buoyancy on y faces.
    function longint face_term(bit [31:0] pa, bit [31:0] pb, bit [15:0] ta, bit [15:0] tb,
                               bit [16:0] wa, bit [16:0] wb, bit [31:0] vel,
                               bit [31:0] inv, bit buoy);
        bit [16:0] ph, pw;
        longint wgt, u, g, ro, bterm;
        bit unused;
        unused = 0;
        ph = clamp_frac((18'(ta) + 18'(tb)) >> 1);
        pw = clamp_frac((18'(wa) + 18'(wb)) >> 1);
        wgt = longint'(64'(ph) * (64'd65536 - 64'(pw)));
        u = longint'(signed'(vel));
        g = longint'(signed'(pb)) - longint'(signed'(pa));
        g = mul_shift(g, longint'(64'(d1)), 16);
        g = mul_shift(g, longint'(64'(inv)), 16);
        g = mul_shift(g, u, 16);
        g = mul_shift(g, wgt, 33);
        if (buoy) begin
            ro = longint'(64'(d1)) +
                 mul_shift(longint'(64'(d2)) - longint'(64'(d1)), longint'(64'(ph)), 16);
            bterm = mul_shift(ro, longint'(signed'(grav)), 16);
            bterm = mul_shift(bterm, u, 16);
            bterm = mul_shift(bterm, wgt, 33);
            g = sat_add(g, bterm, unused);
        end
        return g;
    endfunction

    function void set_reg(t_reg_idx r, bit [31:0] v);
        case (r)
            REG_NX:   nx_reg = v[9:0];
            REG_NY:   ny_reg = v[12:0];
            REG_D1:   d1 = v;
            REG_D2:   d2 = v;
            REG_IDX:  idx = v;
            REG_IDY:  idy = v;
            REG_GRAV: grav = v;
            REG_AREA: area = v;
            default: ;
        endcase
    endfunction

    // Advance the predicted frame state by one accepted cell request.
    function void note_cell(bit [143:0] d);
        int unsigned nx, ny, r, c, cur, prv, ic, il, ir, iu;
        bit [31:0] p_in, vx_in, vy_in;
        bit [15:0] t_in;
        bit [16:0] w_in;
        longint tmp;
        bit unused;
        unused = 0;
        nx = nx_reg; ny = ny_reg;
        if (nx > 1022) nx = 1022;
        r = row_cnt; c = col_cnt % 1024;
        cur = (r & 1) * 1024; prv = ((r + 1) & 1) * 1024;
        p_in = d[31:0]; t_in = d[47:32];
        w_in = 17'(d[63:48]) + 17'(d[79:64]);
        vx_in = d[111:80]; vy_in = d[143:112];
        if (r >= 2 && r <= ny + 1 && c >= 1 && c <= nx) begin
            ic = prv + c; il = prv + c - 1; ir = prv + c + 1; iu = cur + c;
            tmp = 0;
            tmp = sat_add(tmp, face_term(p_rows[il], p_rows[ic], t_rows[il], t_rows[ic],
                w_rows[il], w_rows[ic], vx_rows[il], idx, 0), unused);
            tmp = sat_add(tmp, face_term(p_rows[ic], p_rows[ir], t_rows[ic], t_rows[ir],
                w_rows[ic], w_rows[ir], vx_rows[ic], idx, 0), unused);
            tmp = sat_add(tmp, face_term(p_rows[iu], p_rows[ic], t_rows[iu], t_rows[ic],
                w_rows[iu], w_rows[ic], vy_rows[iu], idy, 1), unused);
            tmp = sat_add(tmp, face_term(p_rows[ic], p_in, t_rows[ic], t_in,
                w_rows[ic], w_in, vy_rows[ic], idy, 1), unused);
            acc = sat_add(acc, mul_shift(tmp, longint'(64'(area)), 0), clip);
        end
        p_rows[cur + c] = p_in; t_rows[cur + c] = t_in; w_rows[cur + c] = w_in;
        vx_rows[cur + c] = vx_in; vy_rows[cur + c] = vy_in;
        if (col_cnt >= nx + 1) begin
            col_cnt = 0;
            if (row_cnt >= ny + 1) begin
                exp_sum.push_back(acc);
                exp_sat.push_back(clip);
                row_cnt = 0; acc = 0; clip = 0;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
    endfunction

    // Compare one accepted frame total with the oldest prediction.
    function void check_total(bit [71:0] d);
        longint es;
        bit esat;
        if (exp_sum.size() == 0) begin
            $display("%0t: unexpected total, actual sum=%h sat=%b", $time, d[63:0], d[64]);
            errors++;
            return;
        end
        es = exp_sum.pop_front();
        esat = exp_sat.pop_front();
        if (d[63:0] !== 64'(es)) begin
            $display("%0t: budget_sum mismatch, expected %h actual %h", $time, es, d[63:0]);
            errors++;
        end
        if (d[64] !== esat) begin
            $display("%0t: saturated mismatch, expected %b actual %b", $time, esat, d[64]);
            errors++;
        end
    endfunction
endclass

module tb_staggered_grid_budget_sum;
    localparam longint CycleLimit = 4000000;
    localparam int     DrainCycles = 200;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;

    budget_scoreboard sb = new();
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    longint cycles = 0;
    int     cells_sent = 0;

    staggered_grid_budget_sum dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Cycle limit guards against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check accepted totals and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_total(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(262143)) - 131072);
        endcase
    endfunction

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [143:0] rand_cell();
        return {rand_word(), rand_word(), rand_frac(), rand_frac(), rand_frac(), rand_word()};
    endfunction

    // Write all eight registers on consecutive edges; only called while idle.
    task automatic write_regs(input logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(t_reg_idx'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Drive one cell request and hold it until accepted.
    task automatic send_cell(input logic [143:0] d);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_cell(d);
        cells_sent++;
    endtask

    // Hold off until every predicted total has arrived, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic random_frame(input int nx, input int ny);
        int eff;
        eff = (nx > 1022) ? 1022 : nx;
        for (int k = 0; k < (eff + 2) * (ny + 2); k++) send_cell(rand_cell());
        drain();
    endtask

    task automatic random_cfg(input int nx, input int ny);
        logic [31:0] v [8];
        v[REG_NX] = 32'(nx);
        v[REG_NY] = 32'(ny);
        for (int i = 2; i < 8; i++)
            v[i] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(131072);
        v[REG_GRAV] = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(1310720)) - 655360);
        write_regs(v);
    endtask

    initial begin
        logic [31:0] v [8];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest frame with an interior cell, extreme registers and extreme cell fields.
        v = '{32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'hFFFF_FFFF};
        write_regs(v);
        for (int k = 0; k < 9; k++) begin
            case (k % 3)
                0: send_cell({32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                              32'h8000_0000});
                1: send_cell({32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'h0000, 16'hFFFF,
                              32'h7FFF_FFFF});
                default: send_cell({32'hFFFF_FFFF, 32'h0000_0001, 16'h0000, 16'h0000, 16'h0000,
                                    32'h0000_0000});
            endcase
        end
        drain();
        // Directed: gentle registers, two columns, phases at the clamp limits.
        v = '{32'd2, 32'd1, 32'd65536, 32'd131072, 32'd65536, 32'd32768,
              32'hFFF6_0000, 32'd0};
        write_regs(v);
        for (int k = 0; k < 12; k++)
            send_cell({32'(k * 1000), 32'(-k * 700), 16'(k * 5000), 16'(k * 6000),
                       (k[0] ? 16'hFFFF : 16'h0000), 32'(k * 65536 - 300000)});
        drain();
        // Empty interior in either direction yields a zero total.
        random_cfg(0, 2);
        random_frame(0, 2);
        random_cfg(2, 0);
        random_frame(2, 0);

        // Random frames across three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 80 : 0;
            recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 8 : 0;
            for (int n = 0; n < 190; ) begin
                int nx, ny;
                nx = $urandom_range(1, 4);
                ny = $urandom_range(1, 3);
                random_cfg(nx, ny);
                random_frame(nx, ny);
                n += (nx + 2) * (ny + 2);
            end
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
